[src/tcps_pkg.sv]
// Package with the shared constants, codes and beat structures of the tick scheduler.
package tcps_pkg;

	localparam int SLOTS = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int BURST_BITS = 16;
	localparam int PRIO_W = 8;
	localparam int TIME_W = 32;

	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_RAN = 2'd2;
	localparam logic [1:0] KIND_IDLE = 2'd3;

	typedef struct packed {
		logic valid;
		logic cls;
		logic [PRIO_W-1:0] prio;
		logic [SLOT_W-1:0] slot;
		logic [BURST_BITS-1:0] remain;
		logic [BURST_BITS-1:0] orig;
		logic [TIME_W-1:0] stamp;
	} cand_t;

	typedef struct packed {
		logic en;
		logic [SLOT_W-1:0] slot;
		logic [BURST_BITS-1:0] burst;
		logic [PRIO_W-1:0] prio;
		logic cls;
		logic [TIME_W-1:0] stamp;
	} wr_t;

	typedef struct packed {
		logic en;
		logic [SLOT_W-1:0] slot;
		logic fin;
	} upd_t;

endpackage

[src/tcps_cell.sv]
// One task slot of the scheduler chain: holds the slot state and passes the best candidate on.
module tcps_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tcps_pkg::SLOT_W-1:0]   my_slot,
	input  tcps_pkg::wr_t                 wr,
	input  tcps_pkg::upd_t                upd,
	input  logic                          go_in,
	input  tcps_pkg::cand_t               cand_in,
	output logic                          go_out,
	output tcps_pkg::cand_t               cand_out,
	output logic                          ready
);
	import tcps_pkg::*;

	logic                  ready_q;
	logic                  cls_q;
	logic [PRIO_W-1:0]     prio_q;
	logic [BURST_BITS-1:0] remain_q;
	logic [BURST_BITS-1:0] orig_q;
	logic [TIME_W-1:0]     stamp_q;
	logic                  go_q;
	cand_t                 cand_q;
	cand_t                 own;
	logic                  take_own;

	always_comb begin
		own.valid  = ready_q;
		own.cls    = cls_q;
		own.prio   = prio_q;
		own.slot   = my_slot;
		own.remain = remain_q;
		own.orig   = orig_q;
		own.stamp  = stamp_q;
		take_own = ready_q && (!cand_in.valid || (cls_q < cand_in.cls) ||
			((cls_q == cand_in.cls) && (prio_q < cand_in.prio)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			go_q <= 1'b0;
		end else begin
			go_q <= go_in;
			if (wr.en && wr.slot == my_slot) begin
				ready_q <= 1'b1;
			end else if (upd.en && upd.slot == my_slot && upd.fin) begin
				ready_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.slot == my_slot) begin
			cls_q <= wr.cls;
			prio_q <= wr.prio;
			remain_q <= wr.burst;
			orig_q <= wr.burst;
			stamp_q <= wr.stamp;
		end else if (upd.en && upd.slot == my_slot && !upd.fin) begin
			remain_q <= remain_q - BURST_BITS'(1);
		end
		if (go_in) begin
			cand_q <= take_own ? own : cand_in;
		end
	end

	assign go_out = go_q;
	assign cand_out = cand_q;
	assign ready = ready_q;

endmodule

[src/two_class_priority_tick_scheduler_top.sv]
// Top level of the two-class preemptive tick scheduler with its chain of slot cells.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------------
//  command  | start / busy     | cmd, task_slot, burst_len, prio_level, class_sel
//  result   | done (one cycle) | kind, ran_slot, finished, finish_time,
//           |                  | turnaround, waiting
//
// An arrival beat's result appears in the next cycle and busy stays low.
// A tick beat walks the best-candidate search along the chain of slot cells one cell a cycle;
// then a winner, if there is one, is updated and the times are formed, else an idle result
// is given.
// Reset clears the time and every slot's ready flag; no clearing pass follows.
// The receiver cannot stall: each result is shown for exactly one cycle.
module two_class_priority_tick_scheduler_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cmd,
	input  logic [3:0]                        task_slot,
	input  logic [15:0]                       burst_len,
	input  logic [7:0]                        prio_level,
	input  logic                              class_sel,
	output logic                              done,
	output logic [1:0]                        kind,
	output logic [3:0]                        ran_slot,
	output logic                              finished,
	output logic [31:0]                       finish_time,
	output logic [31:0]                       turnaround,
	output logic [31:0]                       waiting
);
	import tcps_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [TIME_W-1:0] now_q;
	logic              scan_go_q;
	logic [TIME_W-1:0] tat_q;
	logic              fin_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic [BURST_BITS-1:0] best_orig_q;

	logic        done_q;
	logic [1:0]  kind_q;
	logic [3:0]  ran_slot_q;
	logic        finished_q;
	logic [31:0] finish_time_q;
	logic [31:0] turnaround_q;
	logic [31:0] waiting_q;

	logic [SLOTS-1:0] ready_vec;
	logic [SLOTS:0]   go_chain;
	cand_t            cand_chain [SLOTS+1];
	wr_t              wr;
	upd_t             upd;
	logic             accept;
	logic             in_range;
	logic             reject;
	cand_t            best;
	logic             scan_end;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign in_range = 32'(task_slot) < SLOTS;
	assign reject = !in_range || ready_vec[task_slot[SLOT_W-1:0]];
	assign best = cand_chain[SLOTS];
	assign scan_end = go_chain[SLOTS];

	always_comb begin
		wr.en = accept && cmd == CMD_ARRIVE && !reject;
		wr.slot = task_slot[SLOT_W-1:0];
		wr.burst = burst_len[BURST_BITS-1:0];
		wr.prio = prio_level;
		wr.cls = class_sel;
		wr.stamp = now_q;
		upd.en = (state_q == ST_SCAN) && scan_end && best.valid;
		upd.slot = best.slot;
		upd.fin = best.remain <= BURST_BITS'(1);
	end

	assign go_chain[0] = scan_go_q;
	assign cand_chain[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		tcps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_slot  (SLOT_W'(i)),
			.wr       (wr),
			.upd      (upd),
			.go_in    (go_chain[i]),
			.cand_in  (cand_chain[i]),
			.go_out   (go_chain[i+1]),
			.cand_out (cand_chain[i+1]),
			.ready    (ready_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q <= '0;
			scan_go_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			scan_go_q <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd == CMD_ARRIVE) begin
						done_q <= 1'b1;
					end else if (accept) begin
						scan_go_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						now_q <= now_q + TIME_W'(1);
						if (best.valid) begin
							state_q <= ST_FIN;
						end else begin
							done_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIN: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_ARRIVE) begin
					kind_q <= reject ? KIND_REJECT : KIND_ACCEPT;
					ran_slot_q <= task_slot;
					finished_q <= 1'b0;
					finish_time_q <= '0;
					turnaround_q <= '0;
					waiting_q <= '0;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					tat_q <= now_q - best.stamp + TIME_W'(1);
					fin_q <= upd.fin;
					best_slot_q <= best.slot;
					best_orig_q <= best.orig;
					if (!best.valid) begin
						kind_q <= KIND_IDLE;
						ran_slot_q <= '0;
						finished_q <= 1'b0;
						finish_time_q <= '0;
						turnaround_q <= '0;
						waiting_q <= '0;
					end
				end
			end
			ST_FIN: begin
				kind_q <= KIND_RAN;
				ran_slot_q <= 4'(best_slot_q);
				finished_q <= fin_q;
				finish_time_q <= fin_q ? now_q : '0;
				turnaround_q <= fin_q ? tat_q : '0;
				waiting_q <= fin_q ? (tat_q - TIME_W'(best_orig_q)) : '0;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign kind = kind_q;
	assign ran_slot = ran_slot_q;
	assign finished = finished_q;
	assign finish_time = finish_time_q;
	assign turnaround = turnaround_q;
	assign waiting = waiting_q;

	a_one_scan_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(go_chain))
		else $error("More than one search token is travelling along the cell chain.");

	a_scan_end_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_end |-> state_q == ST_SCAN)
		else $error("The search finished outside the scan state.");

	a_fin_gives_ran: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> done && kind == KIND_RAN)
		else $error("A task was updated but no ran result followed.");

	a_idle_not_finished: assert property (@(posedge clk) disable iff (!arst_n)
		done && kind != KIND_RAN |-> !finished)
		else $error("A result other than a run reports a finished task.");

endmodule
